// ----- rtl/core/dht_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dht_pkg
// Shared types and constants of the double-hashing table: payload words,
// microcode control word fields and the flag group seen by the sequencer.
// ----------------------------------------------------------------------------
package dht_pkg;

    localparam int TABLE_SIZE   = 11;
    localparam int SECOND_PRIME = 7;

    localparam int KEY_W  = 31;
    localparam int OP_W   = 2;
    localparam int STAT_W = 2;
    localparam int SLOT_W = 4;   // holds 0 .. TABLE_SIZE-1
    localparam int STEP_W = 3;   // holds 1 .. SECOND_PRIME
    localparam int PC_W   = 5;
    localparam int ACT_W  = 4;
    localparam int COND_W = 4;

    // Since 2**10 leaves 1 mod 11 and 2**6 leaves 1 mod 7, the sum of the key's
    // 10-bit chunks has the key's residue mod 11, and the sum of its 6-bit
    // chunks has its residue mod 7. A reciprocal multiply then gives the
    // quotient of each folded sum exactly over its whole range.
    localparam int FOLD_T_W   = 12;    // three 10-bit chunks and the top bit
    localparam int FOLD_P_W   = 9;     // five 6-bit chunks and the top bit
    localparam int QUO_T_W    = 9;     // folded sum / 11 is at most 279
    localparam int QUO_P_W    = 6;     // folded sum / 7 is at most 45
    localparam int RECIP_T_W  = 13;
    localparam int RECIP_T    = 5958;  // ceil(2**16 / 11)
    localparam int RECIP_T_SH = 16;
    localparam int RECIP_P_W  = 10;
    localparam int RECIP_P    = 586;   // ceil(2**12 / 7)
    localparam int RECIP_P_SH = 12;

    // Operation codes.
    localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
    localparam logic [OP_W-1:0] OP_SEARCH = 2'd1;
    localparam logic [OP_W-1:0] OP_PAIR   = 2'd2;
    localparam logic [OP_W-1:0] OP_BAD    = 2'd3;

    // Result status codes.
    localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
    localparam logic [STAT_W-1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL      = 2'd2;
    localparam logic [STAT_W-1:0] ST_ZERO      = 2'd3;

    // Datapath actions of one microcode step.
    localparam logic [ACT_W-1:0] A_NONE       = 4'd0;
    localparam logic [ACT_W-1:0] A_MOD_START  = 4'd1;
    localparam logic [ACT_W-1:0] A_MOD_STEP   = 4'd2;
    localparam logic [ACT_W-1:0] A_PROBE_INIT = 4'd3;
    localparam logic [ACT_W-1:0] A_ADVANCE    = 4'd4;
    localparam logic [ACT_W-1:0] A_LOAD_DIFF  = 4'd5;
    localparam logic [ACT_W-1:0] A_SCAN_CLR   = 4'd6;
    localparam logic [ACT_W-1:0] A_SCAN_INC   = 4'd7;
    localparam logic [ACT_W-1:0] A_EMIT_MISS  = 4'd8;
    localparam logic [ACT_W-1:0] A_EMIT_HIT   = 4'd9;
    localparam logic [ACT_W-1:0] A_EMIT_PAIR  = 4'd10;
    localparam logic [ACT_W-1:0] A_EMIT_NF    = 4'd11;
    localparam logic [ACT_W-1:0] A_EMIT_ZERO  = 4'd12;

    // Jump conditions of one microcode step.
    localparam logic [COND_W-1:0] C_NEVER      = 4'd0;
    localparam logic [COND_W-1:0] C_ALWAYS     = 4'd1;
    localparam logic [COND_W-1:0] C_OP_PAIR    = 4'd2;
    localparam logic [COND_W-1:0] C_OP_BAD     = 4'd3;
    localparam logic [COND_W-1:0] C_KEY_ZERO   = 4'd4;
    localparam logic [COND_W-1:0] C_MOD_MORE   = 4'd5;
    localparam logic [COND_W-1:0] C_HIT        = 4'd6;
    localparam logic [COND_W-1:0] C_PROBE_MORE = 4'd7;
    localparam logic [COND_W-1:0] C_SKIP       = 4'd8;
    localparam logic [COND_W-1:0] C_SAME_SLOT  = 4'd9;
    localparam logic [COND_W-1:0] C_SCAN_MORE  = 4'd10;

    typedef struct packed {
        logic [OP_W-1:0]  operation;
        logic [KEY_W-1:0] key;
    } t_cmd;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [SLOT_W-1:0] slot_first;
        logic [SLOT_W-1:0] slot_second;
    } t_result;

    // Control handed from the sequencer to the datapath.
    typedef struct packed {
        logic [ACT_W-1:0] action;
        logic             rd_scan;   // table read address: scan index, else probe slot
    } t_ctrl;

    // Status flags handed from the datapath to the sequencer.
    typedef struct packed {
        logic op_pair;
        logic op_bad;
        logic key_zero;
        logic mod_more;
        logic hit;
        logic probe_more;
        logic skip;
        logic same_slot;
        logic scan_more;
    } t_flags;

endpackage

// ----- rtl/core/dht_seq.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dht_seq
// Microcode sequencer: a step counter walks a read-only program, each word
// giving a datapath action, a read select and a conditional jump.
// ----------------------------------------------------------------------------
module dht_seq
    import dht_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_accept,
    input  t_flags i_flags,
    output t_ctrl  o_ctrl,
    output logic   o_idle
);

    localparam logic [PC_W-1:0] S_IDLE       = 5'd0;
    localparam logic [PC_W-1:0] S_DISP_PAIR  = 5'd1;
    localparam logic [PC_W-1:0] S_DISP_BAD   = 5'd2;
    localparam logic [PC_W-1:0] S_DISP_ZERO  = 5'd3;
    localparam logic [PC_W-1:0] S_MOD_INIT   = 5'd4;
    localparam logic [PC_W-1:0] S_MOD_STEP   = 5'd5;
    localparam logic [PC_W-1:0] S_PROBE_INIT = 5'd6;
    localparam logic [PC_W-1:0] S_PROBE_TEST = 5'd7;
    localparam logic [PC_W-1:0] S_PROBE_NEXT = 5'd8;
    localparam logic [PC_W-1:0] S_MISS       = 5'd9;
    localparam logic [PC_W-1:0] S_EMIT_MISS  = 5'd10;
    localparam logic [PC_W-1:0] S_HIT        = 5'd11;
    localparam logic [PC_W-1:0] S_EMIT_HIT   = 5'd12;
    localparam logic [PC_W-1:0] S_PAIR_INIT  = 5'd13;
    localparam logic [PC_W-1:0] S_PAIR_TEST  = 5'd14;
    localparam logic [PC_W-1:0] S_PAIR_DIFF  = 5'd15;
    localparam logic [PC_W-1:0] S_PAIR_HIT   = 5'd16;
    localparam logic [PC_W-1:0] S_EMIT_PAIR  = 5'd17;
    localparam logic [PC_W-1:0] S_PAIR_NEXT  = 5'd18;
    localparam logic [PC_W-1:0] S_EMIT_NF    = 5'd19;
    localparam logic [PC_W-1:0] S_EMIT_ZERO  = 5'd20;

    logic [PC_W-1:0]   r_pc;
    logic [PC_W-1:0]   n_pc;
    logic [ACT_W-1:0]  uw_action;
    logic              uw_rd_scan;
    logic [COND_W-1:0] uw_cond;
    logic [PC_W-1:0]   uw_target;
    logic              take;

    // Program store.
    always_comb begin
        uw_action  = A_NONE;
        uw_rd_scan = 1'b0;
        uw_cond    = C_NEVER;
        uw_target  = S_IDLE;
        unique case (r_pc)
            S_IDLE: begin
            end
            S_DISP_PAIR: begin
                uw_cond   = C_OP_PAIR;
                uw_target = S_PAIR_INIT;
            end
            S_DISP_BAD: begin
                uw_cond   = C_OP_BAD;
                uw_target = S_EMIT_NF;
            end
            S_DISP_ZERO: begin
                uw_cond   = C_KEY_ZERO;
                uw_target = S_EMIT_ZERO;
            end
            S_MOD_INIT: begin
                uw_action = A_MOD_START;
            end
            S_MOD_STEP: begin
                uw_action = A_MOD_STEP;
                uw_cond   = C_MOD_MORE;
                uw_target = S_MOD_STEP;
            end
            S_PROBE_INIT: begin
                uw_action = A_PROBE_INIT;
            end
            S_PROBE_TEST: begin
                uw_cond   = C_HIT;
                uw_target = S_HIT;
            end
            S_PROBE_NEXT: begin
                uw_action = A_ADVANCE;
                uw_cond   = C_PROBE_MORE;
                uw_target = S_PROBE_TEST;
            end
            S_MISS: begin
                uw_cond   = C_OP_PAIR;
                uw_target = S_PAIR_NEXT;
            end
            S_EMIT_MISS: begin
                uw_action = A_EMIT_MISS;
                uw_cond   = C_ALWAYS;
                uw_target = S_IDLE;
            end
            S_HIT: begin
                uw_cond   = C_OP_PAIR;
                uw_target = S_PAIR_HIT;
            end
            S_EMIT_HIT: begin
                uw_action = A_EMIT_HIT;
                uw_cond   = C_ALWAYS;
                uw_target = S_IDLE;
            end
            S_PAIR_INIT: begin
                uw_action = A_SCAN_CLR;
            end
            S_PAIR_TEST: begin
                uw_rd_scan = 1'b1;
                uw_cond    = C_SKIP;
                uw_target  = S_PAIR_NEXT;
            end
            S_PAIR_DIFF: begin
                uw_rd_scan = 1'b1;
                uw_action  = A_LOAD_DIFF;
                uw_cond    = C_ALWAYS;
                uw_target  = S_MOD_INIT;
            end
            S_PAIR_HIT: begin
                uw_cond   = C_SAME_SLOT;
                uw_target = S_PAIR_NEXT;
            end
            S_EMIT_PAIR: begin
                uw_action = A_EMIT_PAIR;
                uw_cond   = C_ALWAYS;
                uw_target = S_IDLE;
            end
            S_PAIR_NEXT: begin
                uw_action = A_SCAN_INC;
                uw_cond   = C_SCAN_MORE;
                uw_target = S_PAIR_TEST;
            end
            S_EMIT_NF: begin
                uw_action = A_EMIT_NF;
                uw_cond   = C_ALWAYS;
                uw_target = S_IDLE;
            end
            S_EMIT_ZERO: begin
                uw_action = A_EMIT_ZERO;
                uw_cond   = C_ALWAYS;
                uw_target = S_IDLE;
            end
            default: begin
                uw_cond   = C_ALWAYS;
                uw_target = S_IDLE;
            end
        endcase
    end

    always_comb begin
        unique case (uw_cond)
            C_NEVER:      take = 1'b0;
            C_ALWAYS:     take = 1'b1;
            C_OP_PAIR:    take = i_flags.op_pair;
            C_OP_BAD:     take = i_flags.op_bad;
            C_KEY_ZERO:   take = i_flags.key_zero;
            C_MOD_MORE:   take = i_flags.mod_more;
            C_HIT:        take = i_flags.hit;
            C_PROBE_MORE: take = i_flags.probe_more;
            C_SKIP:       take = i_flags.skip;
            C_SAME_SLOT:  take = i_flags.same_slot;
            C_SCAN_MORE:  take = i_flags.scan_more;
            default:      take = 1'b0;
        endcase
    end

    always_comb begin
        if (r_pc == S_IDLE) begin
            n_pc = i_accept ? S_DISP_PAIR : S_IDLE;
        end else if (take) begin
            n_pc = uw_target;
        end else begin
            n_pc = r_pc + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= S_IDLE;
        end else begin
            r_pc <= n_pc;
        end
    end

    assign o_ctrl.action  = uw_action;
    assign o_ctrl.rd_scan = uw_rd_scan;
    assign o_idle         = (r_pc == S_IDLE);

endmodule

// ----- rtl/core/double_hash_table.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// double_hash_table
// Open-addressed hash table with double hashing over eleven 31-bit slots.
// Insert, search and pair-sum queries run as a microcoded program.
//
//   channel  | ports                    | handshake
//   ---------+--------------------------+--------------------------------
//   command  | i_cmd (operation, key)   | taken when start && !busy
//   result   | o_result (status, slots) | one cycle, marked by o_valid
//
// The dispatch steps turn back the unused operation code and a zero key.
// Insert and search probe until a probe decides or all eleven probes miss.
// A pair query scans the slots, passing some over, and looks up the
// difference for each candidate. The remainders are taken by a chunk fold,
// then a reciprocal multiply; the slot table gives one read per cycle. The
// result word shows in the cycle after the final step and busy falls with
// it. Reset empties the table at once. The receiver cannot stall.
// ----------------------------------------------------------------------------
module double_hash_table
    import dht_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    start,
    output logic    busy,
    input  t_cmd    i_cmd,
    output logic    o_valid,
    output t_result o_result
);

    logic [KEY_W-1:0]    r_table [TABLE_SIZE];
    logic [OP_W-1:0]     r_op;
    logic [KEY_W-1:0]    r_key;
    logic [KEY_W-1:0]    r_arg;
    logic                r_mod_cnt;
    logic [FOLD_T_W-1:0] r_fold_t;
    logic [FOLD_P_W-1:0] r_fold_p;
    logic [QUO_T_W-1:0]  r_quo_t;
    logic [QUO_P_W-1:0]  r_quo_p;
    logic [SLOT_W-1:0]   r_mod_t;
    logic [STEP_W-1:0]   r_mod_p;
    logic [SLOT_W-1:0]   r_pos;
    logic [STEP_W-1:0]   r_step;
    logic [SLOT_W-1:0]   r_cnt;
    logic [SLOT_W-1:0]   r_scan;
    logic                r_valid;
    t_result             r_result;

    t_ctrl                         ctrl;
    t_flags                        flags;
    logic                          idle;
    logic                          accept;
    logic [SLOT_W-1:0]             rd_addr;
    logic [KEY_W-1:0]              rd_data;
    logic [KEY_W-1:0]              match_val;
    logic [FOLD_T_W-1:0]           fold_t;
    logic [FOLD_P_W-1:0]           fold_p;
    logic [FOLD_T_W+RECIP_T_W-1:0] prod_t;
    logic [FOLD_P_W+RECIP_P_W-1:0] prod_p;
    logic [FOLD_T_W-1:0]           rem_t;
    logic [FOLD_P_W-1:0]           rem_p;
    logic [SLOT_W:0]               pos_sum;
    logic [SLOT_W-1:0]             n_pos;

    assign accept = start && idle;
    assign busy   = !idle;

    dht_seq u_seq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_flags  (flags),
        .o_ctrl   (ctrl),
        .o_idle   (idle)
    );

    // One table read port, shared by probing and the pair scan.
    assign rd_addr = ctrl.rd_scan ? r_scan : r_pos;
    assign rd_data = r_table[rd_addr];

    // An insert looks for an empty slot; a lookup looks for its argument.
    assign match_val = (r_op == OP_INSERT) ? '0 : r_arg;

    // Remainders by both primes. The first step folds the key into a short sum;
    // the next two take the quotient by reciprocal multiply and subtract it out.
    always_comb begin
        fold_t = FOLD_T_W'(r_arg[9:0]) + FOLD_T_W'(r_arg[19:10])
               + FOLD_T_W'(r_arg[29:20]) + FOLD_T_W'(r_arg[30]);
        fold_p = FOLD_P_W'(r_arg[5:0]) + FOLD_P_W'(r_arg[11:6])
               + FOLD_P_W'(r_arg[17:12]) + FOLD_P_W'(r_arg[23:18])
               + FOLD_P_W'(r_arg[29:24]) + FOLD_P_W'(r_arg[30]);
        prod_t = (FOLD_T_W+RECIP_T_W)'(r_fold_t) * (FOLD_T_W+RECIP_T_W)'(RECIP_T);
        prod_p = (FOLD_P_W+RECIP_P_W)'(r_fold_p) * (FOLD_P_W+RECIP_P_W)'(RECIP_P);
        rem_t  = r_fold_t - FOLD_T_W'(r_quo_t) * FOLD_T_W'(TABLE_SIZE);
        rem_p  = r_fold_p - FOLD_P_W'(r_quo_p) * FOLD_P_W'(SECOND_PRIME);
    end

    always_comb begin
        pos_sum = {1'b0, r_pos} + {2'b00, r_step};
        n_pos   = (pos_sum >= (SLOT_W+1)'(TABLE_SIZE))
                ? SLOT_W'(pos_sum - (SLOT_W+1)'(TABLE_SIZE)) : SLOT_W'(pos_sum);
    end

    always_comb begin
        flags.op_pair    = (r_op == OP_PAIR);
        flags.op_bad     = (r_op == OP_BAD);
        flags.key_zero   = (r_key == '0);
        flags.mod_more   = r_mod_cnt;
        flags.hit        = (rd_data == match_val);
        flags.probe_more = (r_cnt != SLOT_W'(TABLE_SIZE - 1));
        flags.skip       = (rd_data == '0) || (rd_data >= r_key);
        flags.same_slot  = (r_pos == r_scan);
        flags.scan_more  = (r_scan != SLOT_W'(TABLE_SIZE - 1));
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op  <= i_cmd.operation;
            r_key <= i_cmd.key;
            r_arg <= i_cmd.key;
        end
        unique case (ctrl.action)
            A_MOD_START: begin
                r_fold_t  <= fold_t;
                r_fold_p  <= fold_p;
                r_mod_cnt <= 1'b1;
            end
            A_MOD_STEP: begin
                // The remainder is right on the second pass, once the
                // quotient has been registered.
                r_quo_t   <= prod_t[RECIP_T_SH +: QUO_T_W];
                r_quo_p   <= prod_p[RECIP_P_SH +: QUO_P_W];
                r_mod_t   <= rem_t[SLOT_W-1:0];
                r_mod_p   <= rem_p[STEP_W-1:0];
                r_mod_cnt <= 1'b0;
            end
            A_PROBE_INIT: begin
                r_pos  <= r_mod_t;
                r_step <= STEP_W'(SECOND_PRIME) - r_mod_p;
                r_cnt  <= '0;
            end
            A_ADVANCE: begin
                r_pos <= n_pos;
                r_cnt <= r_cnt + 1'b1;
            end
            A_LOAD_DIFF: begin
                r_arg <= r_key - rd_data;
            end
            A_SCAN_CLR: begin
                r_scan <= '0;
            end
            A_SCAN_INC: begin
                r_scan <= r_scan + 1'b1;
            end
            default: begin
            end
        endcase
    end

    // Slot table and result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < TABLE_SIZE; i++) begin
                r_table[i] <= '0;
            end
            r_valid <= 1'b0;
        end else begin
            r_valid <= 1'b0;
            unique case (ctrl.action)
                A_EMIT_MISS: begin
                    r_valid  <= 1'b1;
                    r_result <= '{status: (r_op == OP_INSERT) ? ST_FULL : ST_NOT_FOUND,
                                  slot_first: '0, slot_second: '0};
                end
                A_EMIT_HIT: begin
                    if (r_op == OP_INSERT) begin
                        r_table[r_pos] <= r_key;
                    end
                    r_valid  <= 1'b1;
                    r_result <= '{status: ST_OK, slot_first: r_pos, slot_second: '0};
                end
                A_EMIT_PAIR: begin
                    r_valid  <= 1'b1;
                    r_result <= '{status: ST_OK, slot_first: r_scan, slot_second: r_pos};
                end
                A_EMIT_NF: begin
                    r_valid  <= 1'b1;
                    r_result <= '{status: ST_NOT_FOUND, slot_first: '0, slot_second: '0};
                end
                A_EMIT_ZERO: begin
                    r_valid  <= 1'b1;
                    r_result <= '{status: ST_ZERO, slot_first: '0, slot_second: '0};
                end
                default: begin
                end
            endcase
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule
